>>> hw/rtl/ntoa_pkg.sv
// ----------------------------------------------------------------------------
// ntoa_pkg
// Shared types and constants for the number-to-ASCII formatter.
// ----------------------------------------------------------------------------
package ntoa_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned DIGIT_W = 4;

  // Reciprocal of ten: q = (v * RECIP10) >> RECIP_SHIFT is exact for 32-bit v
  localparam logic [VALUE_W-1:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int unsigned        RECIP_SHIFT = 35;
  localparam int unsigned        PROD_W      = 2 * VALUE_W;

  // Output format selector
  typedef enum logic [1:0] {
    FMT_UDEC  = 2'd0,
    FMT_SDEC  = 2'd1,
    FMT_FIXED = 2'd2,
    FMT_HEX   = 2'd3
  } fmt_t;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [CHAR_W-1:0] CH_UPPER = 8'h41;  // 'A'
  localparam logic [DIGIT_W-1:0] TEN     = 4'hA;

  // One digit (decimal or hex) to its ASCII code
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] code;
    if (d < TEN) begin
      code = CH_ZERO + {4'd0, d};
    end else begin
      code = CH_UPPER + {4'd0, d - TEN};
    end
    return code;
  endfunction

endpackage

>>> hw/rtl/number_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// number_to_ascii_formatter
// Prints a 32-bit value as ASCII text, one character per cycle, MSB first.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low: action selects
//   unsigned decimal, signed decimal, fixed point with one decimal, or
//   upper-case hex; value is the number. busy stays high until the last
//   character has been driven.
//   Each character appears on char_code for one cycle with strobe high;
//   last marks the final character. The receiver cannot stall the block.
// Timing:
//   Decimal digits come from a shared divide-by-ten unit (reciprocal
//   multiply), one digit per pass through S_MUL then S_DIG, stored in a
//   ten-entry digit buffer, then read back one character per cycle. Hex
//   digits go into the same buffer one nibble per S_HEX step. Decimal
//   text has D digits, at most 10; hex text at most 8. In every format
//   the first character leaves only once every digit is in the buffer.
// Reset:
//   rst (synchronous) returns the sequencer to idle and drops strobe.
// ----------------------------------------------------------------------------
module number_to_ascii_formatter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    action,
  input  logic [ntoa_pkg::VALUE_W-1:0]  value,
  output logic                          strobe,
  output logic [ntoa_pkg::CHAR_W-1:0]   char_code,
  output logic                          last
);
  import ntoa_pkg::*;

  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned IDX_W      = $clog2(MAX_DIGITS);
  localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIG,
    S_HEX,
    S_SIGN,
    S_EMIT
  } state_t;

  state_t              state;
  fmt_t                fmt;
  logic                neg;
  logic                dot_done;
  logic [VALUE_W-1:0]  mag;
  logic [CNT_W-1:0]    cnt;
  logic [DIGIT_W-1:0]  digits [MAX_DIGITS];

  logic [VALUE_W-1:0]  quotient;
  logic [DIGIT_W-1:0]  remainder;
  logic [IDX_W-1:0]    wr_idx;
  logic [IDX_W-1:0]    rd_idx;
  logic                dec_done;

  ntoa_div10 u_div10 (
    .clk       (clk),
    .operand   (mag),
    .quotient  (quotient),
    .remainder (remainder)
  );

  assign busy   = (state != S_IDLE);
  assign wr_idx = IDX_W'(cnt);
  assign rd_idx = IDX_W'(cnt - CNT_W'(1));

  // Fixed point needs at least two digits so the integer part shows "0"
  assign dec_done = (quotient == '0) &&
                    ((fmt != FMT_FIXED) || (cnt != '0));

  // Sequencer, digit buffer and registered outputs
  always_ff @(posedge clk) begin
    strobe <= 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          fmt      <= fmt_t'(action);
          cnt      <= '0;
          dot_done <= 1'b0;
          if ((fmt_t'(action) == FMT_SDEC) && value[VALUE_W-1]) begin
            neg <= 1'b1;
            mag <= ~value + VALUE_W'(1);
          end else begin
            neg <= 1'b0;
            mag <= value;
          end
          state <= (fmt_t'(action) == FMT_HEX) ? S_HEX : S_MUL;
        end
      end
      S_MUL: begin
        state <= S_DIG;
      end
      S_DIG: begin
        digits[wr_idx] <= remainder;
        cnt            <= cnt + CNT_W'(1);
        mag            <= quotient;
        if (dec_done) begin
          state <= neg ? S_SIGN : S_EMIT;
        end else begin
          state <= S_MUL;
        end
      end
      S_HEX: begin
        digits[wr_idx] <= mag[DIGIT_W-1:0];
        cnt            <= cnt + CNT_W'(1);
        mag            <= {{DIGIT_W{1'b0}}, mag[VALUE_W-1:DIGIT_W]};
        if (mag[VALUE_W-1:DIGIT_W] == '0) begin
          state <= S_EMIT;
        end
      end
      S_SIGN: begin
        strobe    <= 1'b1;
        char_code <= CH_MINUS;
        last      <= 1'b0;
        state     <= S_EMIT;
      end
      S_EMIT: begin
        strobe <= 1'b1;
        if ((fmt == FMT_FIXED) && (cnt == CNT_W'(1)) && !dot_done) begin
          // decimal point before the fraction digit
          char_code <= CH_DOT;
          last      <= 1'b0;
          dot_done  <= 1'b1;
        end else begin
          char_code <= digit_to_ascii(digits[rd_idx]);
          last      <= (cnt == CNT_W'(1));
          cnt       <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state <= S_IDLE;
          end
        end
      end
      default: begin
        state <= S_IDLE;
      end
    endcase
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end
  end

endmodule

>>> hw/rtl/ntoa_div10.sv
// ----------------------------------------------------------------------------
// ntoa_div10
// Divide-by-ten unit: registered reciprocal multiply, then quotient and
// remainder in the following cycle. The operand must hold for both cycles.
// ----------------------------------------------------------------------------
module ntoa_div10 (
  input  logic                          clk,
  input  logic [ntoa_pkg::VALUE_W-1:0]  operand,
  output logic [ntoa_pkg::VALUE_W-1:0]  quotient,
  output logic [ntoa_pkg::DIGIT_W-1:0]  remainder
);
  import ntoa_pkg::*;

  logic [PROD_W-1:0]  prod;
  logic [VALUE_W-1:0] times_ten;

  // Reciprocal product, registered
  always_ff @(posedge clk) begin
    prod <= {{VALUE_W{1'b0}}, operand} * {{VALUE_W{1'b0}}, RECIP10};
  end

  // Quotient from the high product bits; remainder by back-multiply
  assign quotient  = {{RECIP_SHIFT-VALUE_W{1'b0}}, prod[PROD_W-1:RECIP_SHIFT]};
  assign times_ten = {quotient[VALUE_W-4:0], 3'b000} + {quotient[VALUE_W-2:0], 1'b0};
  assign remainder = DIGIT_W'(operand - times_ten);

endmodule

>>> verif/tb_number_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// tb_number_to_ascii_formatter
// Self-checking testbench for the number-to-ASCII formatter.
// ----------------------------------------------------------------------------
// A directed table covers zero and the field extremes in all four formats,
// decimal digit-count boundaries and the most negative signed value. Random
// requests follow, with values shaped toward digit and sign boundaries. Every
// character is checked against a text model built here, in request order,
// while the sender idles for random spans and drains the block at times.
// ----------------------------------------------------------------------------
module tb_number_to_ascii_formatter;
  timeunit 1ns;
  timeprecision 1ps;

  import ntoa_pkg::*;

  localparam int unsigned RANDOM_REQS = 440;
  localparam int unsigned MAX_GAP     = 14;
  localparam int unsigned DRAIN_EVERY = 150;
  localparam int unsigned BURST_SPAN  = 40;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned DEC_BASE    = 10;
  localparam int unsigned HEX_BASE    = 16;

  typedef logic [CHAR_W-1:0] char_t;
  typedef char_t text_t[$];

  typedef struct packed {
    char_t code;
    logic  last;
  } out_char_t;

  typedef struct {
    fmt_t               fmt;
    logic [VALUE_W-1:0] val;
    string              text;  // empty: take the text model's answer
  } dir_row_t;

  logic               clk   = 1'b0;
  logic               rst   = 1'b1;
  logic               start = 1'b0;
  logic [1:0]         action = FMT_UDEC;
  logic [VALUE_W-1:0] value = '0;
  logic               busy;
  logic               strobe;
  char_t              char_code;
  logic               last;

  // Text of the request on the input ports, and characters still owed
  text_t       req_text;
  out_char_t   pending_chars[$];

  int unsigned error_count   = 0;
  int unsigned chars_checked = 0;
  int unsigned longest_text  = 0;
  int unsigned stall_cycles  = 0;
  int unsigned fmt_count[4]  = '{default: 0};

  dir_row_t dir_rows [0:20] = '{
    '{FMT_UDEC,  32'h0000_0000, "0"},
    '{FMT_UDEC,  32'h0000_0009, "9"},
    '{FMT_UDEC,  32'h0000_000A, "10"},
    '{FMT_UDEC,  32'hFFFF_FFFF, "4294967295"},
    '{FMT_UDEC,  32'h3B9A_CA00, "1000000000"},
    '{FMT_UDEC,  32'h075B_CD15, ""},
    '{FMT_SDEC,  32'h0000_0000, "0"},
    '{FMT_SDEC,  32'h7FFF_FFFF, "2147483647"},
    '{FMT_SDEC,  32'h8000_0000, "-2147483648"},
    '{FMT_SDEC,  32'hFFFF_FFFF, "-1"},
    '{FMT_SDEC,  32'hFFFF_FF85, ""},
    '{FMT_FIXED, 32'h0000_0000, "0.0"},
    '{FMT_FIXED, 32'h0000_0009, "0.9"},
    '{FMT_FIXED, 32'h0000_000A, "1.0"},
    '{FMT_FIXED, 32'hFFFF_FFFF, "429496729.5"},
    '{FMT_FIXED, 32'h0000_3039, ""},
    '{FMT_HEX,   32'h0000_0000, "0"},
    '{FMT_HEX,   32'h0000_000A, "A"},
    '{FMT_HEX,   32'hFFFF_FFFF, "FFFFFFFF"},
    '{FMT_HEX,   32'hDEAD_BEEF, ""},
    '{FMT_HEX,   32'h8000_0000, "80000000"}
  };

  number_to_ascii_formatter u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .action    (action),
    .value     (value),
    .strobe    (strobe),
    .char_code (char_code),
    .last      (last)
  );

  always #5 clk = ~clk;

  // Decimal digits of a magnitude, no leading zeros
  function automatic text_t decimal_text(logic [VALUE_W-1:0] mag);
    text_t              t;
    logic [VALUE_W-1:0] r;
    r = mag;
    do begin
      t.push_front(CH_ZERO + char_t'(r % DEC_BASE));
      r = r / DEC_BASE;
    end while (r != 0);
    return t;
  endfunction

  // Upper-case hex digits, no leading zeros
  function automatic text_t hex_text(logic [VALUE_W-1:0] v);
    text_t              t;
    logic [VALUE_W-1:0] r;
    logic [3:0]         nib;
    r = v;
    do begin
      nib = r[3:0];
      if (nib < 4'hA) t.push_front(CH_ZERO + char_t'(nib));
      else t.push_front(CH_UPPER + char_t'(nib - 4'hA));
      r = r / HEX_BASE;
    end while (r != 0);
    return t;
  endfunction

  // Full text the block should print for one request
  function automatic text_t formatted_text(fmt_t f, logic [VALUE_W-1:0] v);
    text_t t;
    case (f)
      FMT_UDEC: t = decimal_text(v);
      FMT_SDEC: begin
        if (v[VALUE_W-1]) begin
          t.push_back(CH_MINUS);
          t = {t, decimal_text(~v + 1'b1)};
        end else begin
          t = decimal_text(v);
        end
      end
      FMT_FIXED: begin
        t = decimal_text(v / DEC_BASE);
        t.push_back(CH_DOT);
        t = {t, decimal_text(v % DEC_BASE)};
      end
      default: t = hex_text(v);
    endcase
    return t;
  endfunction

  // Random value biased toward digit-count, sign and width boundaries
  function automatic logic [VALUE_W-1:0] shaped_value();
    logic [VALUE_W-1:0] p;
    int unsigned        k;
    p = 1;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 99);
      2: begin
        k = $urandom_range(0, 9);
        repeat (k) p = p * DEC_BASE;
        return p + $urandom_range(0, 2) - 1;
      end
      3: return ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFC) + $urandom_range(0, 3);
      4: return p << $urandom_range(0, VALUE_W - 1);
      default: return $urandom >> $urandom_range(0, VALUE_W - 1);
    endcase
  endfunction

  // Present one request after 'gap' idle cycles and hold it until taken
  task automatic issue(fmt_t f, logic [VALUE_W-1:0] v, string typed, int unsigned gap);
    text_t t;
    if (typed.len() != 0) begin
      for (int i = 0; i < typed.len(); i++) t.push_back(typed[i]);
    end else begin
      t = formatted_text(f, v);
    end
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_text = t;
    start  <= 1'b1;
    action <= f;
    value  <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stop sending and wait until every owed character has come out
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_chars.size() != 0) @(negedge clk);
  endtask

  // Scoreboard: check characters, queue new text, watch for stalls
  always @(posedge clk) begin
    out_char_t want;
    logic      progress;
    progress = 1'b0;
    if (!rst) begin
      if (strobe) begin
        progress = 1'b1;
        if (pending_chars.size() == 0) begin
          error_count++;
          $error("char_code 0x%02h with no request outstanding", char_code);
        end else begin
          want = pending_chars.pop_front();
          chars_checked++;
          if (char_code !== want.code) begin
            error_count++;
            $error("char_code: expected 0x%02h, got 0x%02h", want.code, char_code);
          end
          if (last !== want.last) begin
            error_count++;
            $error("last: expected %0b, got %0b", want.last, last);
          end
        end
      end
      if (start && !busy) begin
        progress = 1'b1;
        foreach (req_text[i]) begin
          pending_chars.push_back('{code: req_text[i], last: (i == req_text.size() - 1)});
        end
        fmt_count[action]++;
        if (req_text.size() > longest_text) longest_text = req_text.size();
      end
      stall_cycles = progress ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned gap;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (dir_rows[i]) begin
      issue(dir_rows[i].fmt, dir_rows[i].val, dir_rows[i].text, $urandom_range(0, MAX_GAP));
    end
    wait_drained();

    // Random requests; every third span of requests runs back to back
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % DRAIN_EVERY == DRAIN_EVERY - 1) wait_drained();
      gap = ((n / BURST_SPAN) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
      issue(fmt_t'($urandom_range(0, 3)), shaped_value(), "", gap);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Requests: %0d unsigned, %0d signed, %0d fixed point, %0d hex; idle gaps 0..%0d",
             fmt_count[FMT_UDEC], fmt_count[FMT_SDEC], fmt_count[FMT_FIXED],
             fmt_count[FMT_HEX], MAX_GAP);
    $display("%0d characters compared, longest text %0d characters",
             chars_checked, longest_text);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/ntoa_pkg.sv
hw/rtl/ntoa_div10.sv
hw/rtl/number_to_ascii_formatter.sv
verif/tb_number_to_ascii_formatter.sv
